// ===== hw/rtl/isl_pkg.sv =====
// Package for the indexed stack list: sizes, request and status codes, cell command type.
`timescale 1ns / 1ps
package isl_pkg;

    localparam int DEPTH  = 16;
    localparam int DATA_W = 32;

    localparam int POS_W   = 5;
    localparam int VALUE_W = 32;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;

    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_TAKE   = 2'd1;
    localparam logic [1:0] KIND_PEEK   = 2'd2;
    localparam logic [1:0] KIND_CLEAR  = 2'd3;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_RANGE = 2'd2;
    localparam logic [1:0] STATUS_FULL  = 2'd3;

    typedef logic signed [DATA_W-1:0] word_t;

    typedef struct packed {
        logic load;       // take the new word
        logic from_prev;  // shift toward the bottom (insert)
        logic from_next;  // shift toward the top (take)
    } cell_cmd_t;

    // stored word to the 32-bit result field, sign extended or truncated
    function automatic logic [VALUE_W-1:0] widen(input word_t w);
        widen = VALUE_W'(w);
    endfunction

endpackage

// ===== hw/rtl/isl_cell.sv =====
// One storage cell of the list chain: holds one word, loads or shifts from a neighbor.
`timescale 1ns / 1ps
module isl_cell
    import isl_pkg::*;
(
    input  logic      clk,
    input  cell_cmd_t cmd,
    input  word_t     load_data,
    input  word_t     prev_data,
    input  word_t     next_data,
    output word_t     data
);

    word_t data_reg;
    word_t data_next;

    always_comb
    begin
        data_next = data_reg;
        if (cmd.load)
        begin
            data_next = load_data;
        end
        else if (cmd.from_prev)
        begin
            data_next = prev_data;
        end
        else if (cmd.from_next)
        begin
            data_next = next_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// ===== hw/rtl/indexed_stack_list.sv =====
// Top level of the indexed stack list: request decode, cell chain, count and result register.
//
//  channel | dir | fields (low bit first)
//  --------+-----+------------------------------------------------------------
//  s_axis  | in  | tuser: kind[1:0]; tdata: position[4:0], value_in[36:5]
//  m_axis  | out | tuser: status[1:0]; tdata: value_out[31:0],
//          |     |        entry_count[36:32], is_empty[37]
//
// The cell row shifts in parallel for each accepted request, and the
// result lands in the output register on the accepting edge, one transfer per
// cycle while the output is not stalled. The position read mux and the count
// compare set the path length. Reset clears the count and the output valid;
// cell contents stay undefined. A stalled result holds; a new request is taken
// in the same cycle the held result is taken.
`timescale 1ns / 1ps
module indexed_stack_list
    import isl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // position[4:0], value_in[36:5], zero pad
    input  logic [1:0]  s_axis_tuser,   // kind[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // value_out[31:0], entry_count[36:32], is_empty[37]
    output logic [1:0]  m_axis_tuser    // status[1:0]
);

    logic [CNT_W-1:0]   count_reg, count_next;
    logic               out_valid_reg;
    logic [1:0]         status_reg, status_next;
    logic [VALUE_W-1:0] value_reg, value_next;
    logic [CNT_W-1:0]   out_count_reg;

    logic               accept;
    logic [1:0]         kind;
    logic [POS_W-1:0]   position;
    logic [VALUE_W-1:0] value_in;
    logic [CMP_W-1:0]   pos_cmp, cnt_cmp;
    logic               ins_ok, take_ok;
    logic [IDX_W-1:0]   read_idx;
    word_t              new_word;

    word_t              cell_data [DEPTH];

    assign kind     = s_axis_tuser;
    assign position = s_axis_tdata[POS_W-1:0];
    assign value_in = s_axis_tdata[POS_W+VALUE_W-1:POS_W];
    assign pos_cmp  = CMP_W'(position);
    assign cnt_cmp  = CMP_W'(count_reg);
    assign read_idx = IDX_W'(pos_cmp);
    assign new_word = DATA_W'($signed(value_in));

    // output register frees up when empty or being drained
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign ins_ok  = accept && (kind == KIND_INSERT) && (pos_cmp <= cnt_cmp)
                     && (cnt_cmp < CMP_W'(DEPTH));
    assign take_ok = accept && (kind == KIND_TAKE) && (pos_cmp < cnt_cmp);

    // request decode: status, result word and new count
    always_comb
    begin
        status_next = STATUS_OK;
        value_next  = '0;
        count_next  = count_reg;
        case (kind)
            KIND_INSERT:
            begin
                if (pos_cmp > cnt_cmp)
                begin
                    status_next = STATUS_RANGE;
                end
                else if (cnt_cmp >= CMP_W'(DEPTH))
                begin
                    status_next = STATUS_FULL;
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            KIND_TAKE:
            begin
                if (pos_cmp >= cnt_cmp)
                begin
                    status_next = (pos_cmp == '0) ? STATUS_EMPTY : STATUS_RANGE;
                end
                else
                begin
                    value_next = widen(cell_data[read_idx]);
                    count_next = count_reg - CNT_W'(1);
                end
            end
            KIND_PEEK:
            begin
                if (count_reg == '0)
                begin
                    status_next = STATUS_EMPTY;
                end
                else
                begin
                    value_next = widen(cell_data[0]);
                end
            end
            default:
            begin
                count_next = '0;
            end
        endcase
    end

    // cell row: entry 0 is the top of the list
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        cell_cmd_t cmd;
        word_t     prev_word;
        word_t     next_word;

        assign cmd.load      = ins_ok && (CMP_W'(i) == pos_cmp);
        assign cmd.from_prev = ins_ok && (CMP_W'(i) > pos_cmp);
        assign cmd.from_next = take_ok && (CMP_W'(i) >= pos_cmp);

        if (i == 0)
        begin : g_top
            assign prev_word = new_word;
        end
        else
        begin : g_mid
            assign prev_word = cell_data[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_bottom
            assign next_word = cell_data[i];
        end
        else
        begin : g_inner
            assign next_word = cell_data[i+1];
        end

        isl_cell u_cell (
            .clk       (clk),
            .cmd       (cmd),
            .load_data (new_word),
            .prev_data (prev_word),
            .next_data (next_word),
            .data      (cell_data[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg    <= status_next;
            value_reg     <= value_next;
            out_count_reg <= count_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = status_reg;
    assign m_axis_tdata  = {2'b00, (out_count_reg == '0), POS_W'(out_count_reg), value_reg};

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[37] == (out_count_reg == '0)))
        else $error("empty flag disagrees with count");

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && kind == KIND_CLEAR) |=> (count_reg == '0))
        else $error("clear left entries");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        ins_ok |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("good insert did not grow the list");

    a_take_fail_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && kind == KIND_TAKE && !take_ok) |=> $stable(count_reg))
        else $error("failed take changed the count");
`endif

endmodule

// ===== verif/indexed_stack_list_tb.sv =====
// Self-checking testbench for the indexed stack list: directed corner cases, then random traffic.
`timescale 1ns / 1ps
module indexed_stack_list_tb;
    import isl_pkg::*;

    localparam int CLK_HALF      = 2;
    localparam int RANDOM_ITEMS  = 782;
    localparam int IDLE_PCT      = 28;
    localparam int WATCHDOG_MAX  = 2000;   // cycles with no transfer on either side
    localparam int SETTLE_CYCLES = 4;      // covers the result register plus margin
    localparam int LONG_HOLD     = 80;

    // one result transfer, unpacked from the master side
    typedef struct packed {
        logic [1:0]        status;
        logic [31:0]       value;
        logic [POS_W-1:0]  count;
        logic              empty;
    } list_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;    // position[4:0], value_in[36:5], zero pad
    logic [1:0]  s_axis_tuser;    // kind[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;    // value_out[31:0], entry_count[36:32], is_empty[37]
    logic [1:0]  m_axis_tuser;    // status[1:0]

    // shadow copy of the list, index 0 is the top
    word_t        shadow_list[$];
    list_result_t due_results[$];

    int  error_count;
    bit  src_idle_en;
    bit  sink_idle_en;
    int  sink_hold_req;
    int  sink_hold_left;
    int  quiet_cycles;

    indexed_stack_list dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor: applies one accepted request to the shadow list and
    // queues the result the block must return for it.
    // ------------------------------------------------------------------
    task automatic predict_list_op(input logic [1:0] kind, input logic [POS_W-1:0] pos,
                                   input logic [31:0] val);
        list_result_t r;
        int           idx;
        idx      = int'(pos);
        r.status = STATUS_OK;
        r.value  = '0;
        case (kind)
            KIND_INSERT:
            begin
                if (idx > shadow_list.size())
                    r.status = STATUS_RANGE;
                else if (shadow_list.size() >= DEPTH)
                    r.status = STATUS_FULL;
                else
                    shadow_list.insert(idx, word_t'(val));
            end
            KIND_TAKE:
            begin
                if (idx >= shadow_list.size())
                    r.status = (idx == 0) ? STATUS_EMPTY : STATUS_RANGE;
                else
                begin
                    r.value = shadow_list[idx];
                    shadow_list.delete(idx);
                end
            end
            KIND_PEEK:
            begin
                if (shadow_list.size() == 0)
                    r.status = STATUS_EMPTY;
                else
                    r.value = shadow_list[0];
            end
            default:
                shadow_list.delete();
        endcase
        r.count = POS_W'(shadow_list.size());
        r.empty = (shadow_list.size() == 0);
        due_results.push_back(r);
    endtask

    // ------------------------------------------------------------------
    // Sender: offers one request and returns once it is transferred.
    // Optional idle gap goes in front, so tvalid gets one NBA per step.
    // ------------------------------------------------------------------
    task automatic send_request(input logic [1:0] kind, input logic [POS_W-1:0] pos,
                                input logic [31:0] val);
        if (src_idle_en && $urandom_range(99) < IDLE_PCT)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {3'b000, val, pos};
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_list_op(kind, pos, val);
    endtask

    // Sender goes quiet until every queued result has come back.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Receiver: random tready, plus long holds requested by the tests.
    // ------------------------------------------------------------------
    initial
    begin
        m_axis_tready  = 1'b0;
        sink_hold_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (sink_hold_req != 0)
            begin
                sink_hold_left = sink_hold_req;
                sink_hold_req  = 0;
            end
            if (sink_hold_left > 0)
            begin
                sink_hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= !(sink_idle_en && $urandom_range(99) < IDLE_PCT);
        end
    end

    // ------------------------------------------------------------------
    // Result checker: every result transfer against the oldest prediction.
    // ------------------------------------------------------------------
    initial
    begin
        list_result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
            begin
                if (due_results.size() == 0)
                begin
                    $error("result with nothing expected: tdata=%h tuser=%h",
                           m_axis_tdata, m_axis_tuser);
                    error_count++;
                end
                else
                begin
                    want = due_results.pop_front();
                    if (m_axis_tuser !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
                        error_count++;
                    end
                    if (m_axis_tdata[31:0] !== want.value)
                    begin
                        $error("value_out: expected %h, got %h", want.value,
                               m_axis_tdata[31:0]);
                        error_count++;
                    end
                    if (m_axis_tdata[36:32] !== want.count)
                    begin
                        $error("entry_count: expected %0d, got %0d", want.count,
                               m_axis_tdata[36:32]);
                        error_count++;
                    end
                    if (m_axis_tdata[37] !== want.empty)
                    begin
                        $error("is_empty: expected %0d, got %0d", want.empty,
                               m_axis_tdata[37]);
                        error_count++;
                    end
                end
            end
        end
    end

    // Watchdog: too long without any transfer means the block is stuck.
    initial
    begin
        quiet_cycles = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_MAX)
            begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Requests on an empty list: the empty and range failure statuses, then clear when empty.
    task automatic test_empty_list();
        send_request(KIND_PEEK,   5'd0,  32'h1234_5678);
        send_request(KIND_TAKE,   5'd0,  32'h0);
        send_request(KIND_TAKE,   5'd3,  32'h0);
        send_request(KIND_TAKE,   5'd16, 32'h0);
        send_request(KIND_INSERT, 5'd1,  32'hdead_beef);
        send_request(KIND_CLEAR,  5'd31, 32'hffff_ffff);
        drain_results();
    endtask

    // Push, insert in the middle and at the bottom, take from each place.
    task automatic test_insert_take_positions();
        send_request(KIND_INSERT, 5'd0, 32'h7fff_ffff);
        send_request(KIND_INSERT, 5'd0, 32'h8000_0000);
        send_request(KIND_INSERT, 5'd2, 32'h0000_0000);   // at the bottom
        send_request(KIND_INSERT, 5'd1, 32'hffff_ffff);   // in the middle
        send_request(KIND_INSERT, 5'd5, 32'h5555_5555);   // past the count
        send_request(KIND_PEEK,   5'd0, 32'h0);
        send_request(KIND_TAKE,   5'd4, 32'h0);           // equal to the count
        send_request(KIND_TAKE,   5'd2, 32'h0);
        send_request(KIND_TAKE,   5'd2, 32'h0);           // last entry
        send_request(KIND_TAKE,   5'd0, 32'h0);
        send_request(KIND_CLEAR,  5'd0, 32'h0);
        drain_results();
    endtask

    // Fill to DEPTH, then hit the full case at both ends and the range case past the bottom.
    task automatic test_full_list();
        for (int i = 0; i < DEPTH; i++)
            send_request(KIND_INSERT, POS_W'($urandom_range(i)), $urandom);
        send_request(KIND_INSERT, 5'd0,  32'haaaa_aaaa);
        send_request(KIND_INSERT, 5'd16, 32'haaaa_aaaa);
        send_request(KIND_TAKE,   5'd16, 32'h0);
        send_request(KIND_TAKE,   5'd15, 32'h0);
        send_request(KIND_CLEAR,  5'd0,  32'h0);
        drain_results();
    endtask

    // Random request mix; mostly valid positions so the list moves across
    // all fill levels, with some out-of-range positions mixed in.
    task automatic random_request();
        logic [1:0]       kind;
        logic [POS_W-1:0] pos;
        logic [31:0]      val;
        int               pick;
        int               fill;
        int               ins_pct;
        fill    = shadow_list.size();
        ins_pct = (fill < 12) ? 55 : 40;
        pick    = $urandom_range(99);
        if (pick < ins_pct)
            kind = KIND_INSERT;
        else if (pick < 88)
            kind = KIND_TAKE;
        else if (pick < 98)
            kind = KIND_PEEK;
        else
            kind = KIND_CLEAR;
        if ($urandom_range(99) < 85)
        begin
            if (kind == KIND_INSERT)
                pos = POS_W'($urandom_range(fill));
            else if (kind == KIND_TAKE && fill > 0)
                pos = POS_W'($urandom_range(fill - 1));
            else
                pos = POS_W'($urandom_range(DEPTH));
        end
        else
            pos = POS_W'($urandom_range(DEPTH));
        case ($urandom_range(19))
            0:       val = 32'h7fff_ffff;
            1:       val = 32'h8000_0000;
            2:       val = 32'h0000_0000;
            3:       val = 32'hffff_ffff;
            default: val = $urandom;
        endcase
        send_request(kind, pos, val);
    endtask

    // Receiver holds off long enough that the result register fills and
    // tready drops while the sender keeps offering.
    task automatic test_output_stall();
        sink_hold_req = LONG_HOLD;
        for (int i = 0; i < 30; i++)
            random_request();
        drain_results();
    endtask

    // Bulk random traffic: a first stretch with no idling on either side,
    // then random idling on both sides with one long receiver hold.
    task automatic test_random_traffic();
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == 200)
            begin
                src_idle_en  = 1'b1;
                sink_idle_en = 1'b1;
            end
            if (i == 500)
                sink_hold_req = LONG_HOLD;
            if (i == 650)
                drain_results();
            random_request();
        end
        drain_results();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        error_count   = 0;
        src_idle_en   = 1'b1;
        sink_idle_en  = 1'b1;
        sink_hold_req = 0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = KIND_PEEK;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_list();
        test_insert_take_positions();
        test_full_list();
        test_output_stall();
        test_random_traffic();

        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/isl_pkg.sv
hw/rtl/isl_cell.sv
hw/rtl/indexed_stack_list.sv
verif/indexed_stack_list_tb.sv
